@@ design/nipa_pkg.sv @@
// ---------------------------------------------------------------------------
// Nearest idle point assigner: shared definitions
// Widths, default parameter values, status codes and register indexes.
// ---------------------------------------------------------------------------
`default_nettype none

package nipa_pkg;

   // Default values for the top-level parameters.
   localparam int DEF_MAX_SLOTS   = 256;
   localparam int DEF_COORD_BITS  = 24;

   // Fixed field widths.
   localparam int SLOT_PORT_W     = 8;
   localparam int SERVER_ID_W     = 16;
   localparam int RIDER_W         = 16;
   localparam int TOTAL_W         = 16;
   localparam int STATUS_W        = 3;
   localparam int DRV_COUNT_W     = 9;

   // Register port.
   localparam int CSR_IDX_W       = 1;
   localparam int CSR_DATA_W      = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_DRIVER_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_RIDER_COUNT  = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STAT_LOADED      = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_MATCHED     = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_NO_IDLE     = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_NOT_PENDING = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_BAD_RIDER   = 3'd4;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

endpackage : nipa_pkg

`default_nettype wire

@@ design/nearest_idle_point_assigner_core.sv @@
// ---------------------------------------------------------------------------
// Nearest idle point assigner core
// Keeps a table of server points and assigns each valid request to the
// idle point nearest to it by squared distance, marking that point busy.
// ---------------------------------------------------------------------------
//
//   channel   ports                         handshake
//   -------   ---------------------------   ---------------------------------
//   request   req_*                         beat taken when start & !busy
//   result    rsp_*                         one beat per rsp_strobe cycle
//   config    csr_we, csr_index, csr_wdata  write taken when csr_we is high
//
// Load items and rejected requests give their result beat in the next
// cycle and busy stays low. A match request holds busy high while it scans
// the first driver_count slots, at most MAX_SLOTS: the point memory has one
// read port and the scan reads one slot per cycle, followed by a three-stage
// distance pipeline. After reset a clearing pass marks every slot busy;
// busy is high meanwhile and register writes are still taken.
// The result side has no back-pressure.
// ---------------------------------------------------------------------------
`default_nettype none

module nearest_idle_point_assigner_core
   import nipa_pkg::*;
#(
   parameter int MAX_SLOTS  = DEF_MAX_SLOTS,
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_mode,
   input  wire logic [SLOT_PORT_W-1:0]        req_slot_index,
   input  wire logic signed [COORD_BITS-1:0]  req_pos_x,
   input  wire logic signed [COORD_BITS-1:0]  req_pos_y,
   input  wire logic [SERVER_ID_W-1:0]        req_server_id,
   input  wire logic                          req_server_idle,
   input  wire logic [RIDER_W-1:0]            req_rider_id,
   input  wire logic                          req_ride_pending,

   output logic                               rsp_strobe,
   output logic [STATUS_W-1:0]                rsp_status,
   output logic [SLOT_PORT_W-1:0]             rsp_chosen_slot,
   output logic [SERVER_ID_W-1:0]             rsp_chosen_id,
   output logic [2*COORD_BITS:0]              rsp_distance_squared,
   output logic [TOTAL_W-1:0]                 rsp_match_total,

   input  wire logic                          csr_we,
   input  wire logic [CSR_IDX_W-1:0]          csr_index,
   input  wire logic [CSR_DATA_W-1:0]         csr_wdata
);

   localparam int SLOT_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int COUNT_W = $clog2(MAX_SLOTS + 1);
   localparam int CB      = COORD_BITS;
   localparam int SQ_W    = 2 * CB;
   localparam int DIST_W  = 2 * CB + 1;
   localparam int POINT_W = SERVER_ID_W + 2 * CB;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN
   } state_type;

   // ------------------------------------------------------------------
   // Memories: point data (x, y, id) and the idle flag of each slot.
   // ------------------------------------------------------------------
   logic [POINT_W-1:0] mem_point [MAX_SLOTS];
   logic               mem_idle  [MAX_SLOTS];

   logic [POINT_W-1:0] point_rd_ff;
   logic               idle_rd_ff;

   // Control registers.
   state_type            state_ff, state_in;
   logic [SLOT_W-1:0]    clr_addr_ff, clr_addr_in;
   logic [COUNT_W-1:0]   addr_ff, addr_in;
   logic [COUNT_W-1:0]   n_ff, n_in;
   logic                 v1_ff, v1_in;
   logic                 v2_ff, v2_in;
   logic                 v3_ff, v3_in;
   logic                 found_ff, found_in;
   logic [TOTAL_W-1:0]   count_ff, count_in;
   logic [DRV_COUNT_W-1:0] drv_ff, drv_in;
   logic [RIDER_W-1:0]   rider_cnt_ff, rider_cnt_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;

   // Datapath registers.
   logic signed [CB-1:0] px_ff, py_ff;
   logic [SLOT_W-1:0]    idx1_ff, idx2_ff, idx3_ff;
   logic [CB-1:0]        dx_ff, dy_ff, dx_in, dy_in;
   logic [SERVER_ID_W-1:0] id2_ff, id3_ff;
   logic [SQ_W-1:0]      sqx_ff, sqy_ff, sqx_in, sqy_in;
   logic [DIST_W-1:0]    best_d_ff;
   logic [SLOT_W-1:0]    best_idx_ff;
   logic [SERVER_ID_W-1:0] best_id_ff;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [SLOT_PORT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [SERVER_ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic [DIST_W-1:0]    rsp_dist_ff, rsp_dist_in;

   // Combinational signals.
   logic                 accept;
   logic                 slot_ok;
   logic                 rider_bad;
   logic                 issue;
   logic                 scan_done;
   logic                 take;
   logic [DIST_W-1:0]    sum;
   logic                 point_we;
   logic [SLOT_W-1:0]    load_addr;
   logic                 idle_we;
   logic [SLOT_W-1:0]    idle_waddr;
   logic                 idle_wdata;
   logic [SLOT_W-1:0]    rd_addr;
   logic signed [CB:0]   dx_full, dy_full, dx_neg, dy_neg;
   logic signed [CB-1:0] x1, y1;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && (state_ff == S_IDLE);
   assign slot_ok   = (32'(req_slot_index) < 32'(MAX_SLOTS));
   assign load_addr = SLOT_W'(req_slot_index);
   assign rider_bad = (req_rider_id == '0) || (req_rider_id > rider_cnt_ff);
   assign issue     = (state_ff == S_SCAN) && (addr_ff < n_ff);
   assign scan_done = !issue && !v1_ff && !v2_ff && !v3_ff;
   assign rd_addr   = addr_ff[SLOT_W-1:0];
   assign point_we  = accept && !req_mode && slot_ok;

   // ------------------------------------------------------------------
   // Distance pipeline: difference, square, then sum and compare.
   // ------------------------------------------------------------------
   assign x1 = point_rd_ff[CB-1:0];
   assign y1 = point_rd_ff[SQ_W-1:CB];

   always_comb begin
      dx_full = {x1[CB-1], x1} - {px_ff[CB-1], px_ff};
      dy_full = {y1[CB-1], y1} - {py_ff[CB-1], py_ff};
      dx_neg  = -dx_full;
      dy_neg  = -dy_full;
      dx_in   = dx_full[CB] ? dx_neg[CB-1:0] : dx_full[CB-1:0];
      dy_in   = dy_full[CB] ? dy_neg[CB-1:0] : dy_full[CB-1:0];
      sqx_in  = {{CB{1'b0}}, dx_ff} * {{CB{1'b0}}, dx_ff};
      sqy_in  = {{CB{1'b0}}, dy_ff} * {{CB{1'b0}}, dy_ff};
   end

   assign sum  = DIST_W'(sqx_ff) + DIST_W'(sqy_ff);
   // Strict less-than keeps the lowest slot on a tie.
   assign take = v3_ff && (!found_ff || (sum < best_d_ff));

   // ------------------------------------------------------------------
   // Control.
   // ------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      addr_in       = addr_ff;
      n_in          = n_ff;
      v1_in         = issue;
      v2_in         = v1_ff && idle_rd_ff;
      v3_in         = v2_ff;
      found_in      = found_ff || take;
      count_in      = count_ff;
      drv_in        = drv_ff;
      rider_cnt_in  = rider_cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = STAT_LOADED;
      rsp_slot_in   = '0;
      rsp_id_in     = '0;
      rsp_dist_in   = '0;
      idle_we       = 1'b0;
      idle_waddr    = load_addr;
      idle_wdata    = req_server_idle;

      if (csr_we) begin
         unique case (csr_index)
            CSR_DRIVER_COUNT: drv_in       = csr_wdata[DRV_COUNT_W-1:0];
            CSR_RIDER_COUNT:  rider_cnt_in = csr_wdata[RIDER_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            idle_we     = 1'b1;
            idle_waddr  = clr_addr_ff;
            idle_wdata  = 1'b0;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == SLOT_W'(MAX_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (!req_mode) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STAT_LOADED;
                  idle_we       = slot_ok;
               end else if (!req_ride_pending) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STAT_NOT_PENDING;
               end else if (rider_bad) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STAT_BAD_RIDER;
               end else begin
                  state_in = S_SCAN;
                  addr_in  = '0;
                  found_in = 1'b0;
                  n_in     = (32'(drv_ff) > 32'(MAX_SLOTS)) ? COUNT_W'(MAX_SLOTS)
                                                            : COUNT_W'(drv_ff);
               end
            end
         end
         S_SCAN: begin
            if (issue) begin
               addr_in = addr_ff + 1'b1;
            end
            // All slots read and merged: best_* hold the final winner.
            if (scan_done) begin
               state_in      = S_IDLE;
               rsp_strobe_in = 1'b1;
               if (found_ff) begin
                  rsp_status_in = STAT_MATCHED;
                  rsp_slot_in   = SLOT_PORT_W'(best_idx_ff);
                  rsp_id_in     = best_id_ff;
                  rsp_dist_in   = best_d_ff;
                  idle_we       = 1'b1;
                  idle_waddr    = best_idx_ff;
                  idle_wdata    = 1'b0;
                  count_in      = (count_ff == TOTAL_MAX) ? count_ff
                                                          : count_ff + 1'b1;
               end else begin
                  rsp_status_in = STAT_NO_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_addr_ff   <= '0;
         addr_ff       <= '0;
         n_ff          <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         found_ff      <= 1'b0;
         count_ff      <= '0;
         drv_ff        <= '0;
         rider_cnt_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         addr_ff       <= addr_in;
         n_ff          <= n_in;
         v1_ff         <= v1_in;
         v2_ff         <= v2_in;
         v3_ff         <= v3_in;
         found_ff      <= found_in;
         count_ff      <= count_in;
         drv_ff        <= drv_in;
         rider_cnt_ff  <= rider_cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff <= req_pos_x;
         py_ff <= req_pos_y;
      end
      idx1_ff <= rd_addr;
      idx2_ff <= idx1_ff;
      idx3_ff <= idx2_ff;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      id2_ff  <= point_rd_ff[POINT_W-1:SQ_W];
      id3_ff  <= id2_ff;
      sqx_ff  <= sqx_in;
      sqy_ff  <= sqy_in;
      if (take) begin
         best_d_ff   <= sum;
         best_idx_ff <= idx3_ff;
         best_id_ff  <= id3_ff;
      end
      if (rsp_strobe_in) begin
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_dist_ff   <= rsp_dist_in;
      end
   end

   // Memory ports. Writes happen only in the clear, idle and final scan
   // cycles, never while a scan reads, so no forwarding is needed.
   always_ff @(posedge clock) begin
      if (point_we) begin
         mem_point[load_addr] <= {req_server_id, req_pos_y, req_pos_x};
      end
      if (issue) begin
         point_rd_ff <= mem_point[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (idle_we) begin
         mem_idle[idle_waddr] <= idle_wdata;
      end
      if (issue) begin
         idle_rd_ff <= mem_idle[rd_addr];
      end
   end

   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_chosen_slot      = rsp_slot_ff;
   assign rsp_chosen_id        = rsp_id_ff;
   assign rsp_distance_squared = rsp_dist_ff;
   assign rsp_match_total      = count_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   a_scan_starts: assert property (@(posedge clock) disable iff (reset)
      accept && req_mode && req_ride_pending && !rider_bad |=> busy)
      else $error("valid match request did not start a scan");

   a_pipe_in_scan: assert property (@(posedge clock) disable iff (reset)
      (v1_ff || v2_ff || v3_ff) |-> (state_ff == S_SCAN))
      else $error("distance pipeline active outside a scan");

   a_match_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == STAT_MATCHED) |-> (rsp_match_total != '0))
      else $error("matched beat with a zero match total");

   a_no_match_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status != STAT_MATCHED)
         |-> (rsp_chosen_slot == '0) && (rsp_chosen_id == '0)
             && (rsp_distance_squared == '0))
      else $error("unmatched beat carries nonzero match fields");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !rsp_strobe |-> $stable(count_ff))
      else $error("match total changed without a result beat");

endmodule : nearest_idle_point_assigner_core

`default_nettype wire

@@ verif/tb_nearest_idle_point_assigner_core.sv @@
// ---------------------------------------------------------------------------
// Nearest idle point assigner core: self-checking testbench
// Fills the point table, runs a directed sequence through every status code,
// then random load and request traffic under many register settings,
// and a run of back-to-back load and match pairs on a single slot.
// A predictor keeps its own copy of the table and checks every result beat.
// ---------------------------------------------------------------------------

module tb_nearest_idle_point_assigner_core;
   import nipa_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = DEF_MAX_SLOTS;
   localparam int CW    = DEF_COORD_BITS;
   localparam int DW    = 2*CW + 1;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int ERROR_PRINT_CAP = 40;
   localparam int PAIR_ROUNDS = 32;
   localparam bit MODE_LOAD    = 1'b0;
   localparam bit MODE_REQUEST = 1'b1;
   localparam bit signed [CW-1:0] COORD_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam bit signed [CW-1:0] COORD_MIN = {1'b1, {(CW-1){1'b0}}};

   typedef struct {
      bit                      mode;
      bit [SLOT_PORT_W-1:0]    slot;
      bit signed [CW-1:0]      x;
      bit signed [CW-1:0]      y;
      bit [SERVER_ID_W-1:0]    ident;
      bit                      idle;
      bit [RIDER_W-1:0]        rider;
      bit                      pending;
      int unsigned             gap;
   } job_type;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [SLOT_PORT_W-1:0]  slot;
      logic [SERVER_ID_W-1:0]  ident;
      logic [DW-1:0]           sq_dist;
      logic [TOTAL_W-1:0]      total;
   } reply_type;

   logic clock;
   logic reset = 1'b1;

   logic                      start = 1'b0;
   logic                      busy;
   logic                      req_mode = 1'b0;
   logic [SLOT_PORT_W-1:0]    req_slot_index = '0;
   logic signed [CW-1:0]      req_pos_x = '0;
   logic signed [CW-1:0]      req_pos_y = '0;
   logic [SERVER_ID_W-1:0]    req_server_id = '0;
   logic                      req_server_idle = 1'b0;
   logic [RIDER_W-1:0]        req_rider_id = '0;
   logic                      req_ride_pending = 1'b0;

   logic                      rsp_strobe;
   logic [STATUS_W-1:0]       rsp_status;
   logic [SLOT_PORT_W-1:0]    rsp_chosen_slot;
   logic [SERVER_ID_W-1:0]    rsp_chosen_id;
   logic [DW-1:0]             rsp_distance_squared;
   logic [TOTAL_W-1:0]        rsp_match_total;

   logic                      csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = CSR_DRIVER_COUNT;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   nearest_idle_point_assigner_core uut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_mode             (req_mode),
      .req_slot_index       (req_slot_index),
      .req_pos_x            (req_pos_x),
      .req_pos_y            (req_pos_y),
      .req_server_id        (req_server_id),
      .req_server_idle      (req_server_idle),
      .req_rider_id         (req_rider_id),
      .req_ride_pending     (req_ride_pending),
      .rsp_strobe           (rsp_strobe),
      .rsp_status           (rsp_status),
      .rsp_chosen_slot      (rsp_chosen_slot),
      .rsp_chosen_id        (rsp_chosen_id),
      .rsp_distance_squared (rsp_distance_squared),
      .rsp_match_total      (rsp_match_total),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   // Predictor state: the point table, the match tally and the registers.
   bit signed [CW-1:0]     pt_x     [SLOTS];
   bit signed [CW-1:0]     pt_y     [SLOTS];
   bit [SERVER_ID_W-1:0]   pt_ident [SLOTS];
   bit                     pt_idle  [SLOTS];
   bit [TOTAL_W-1:0]       tally = '0;
   bit [DRV_COUNT_W-1:0]   cfg_drivers = '0;
   bit [RIDER_W-1:0]       cfg_riders = '0;

   job_type     pending_jobs[$];
   reply_type   pending_replies[$];
   job_type     cur_job;
   bit          carrying = 1'b0;
   int unsigned jobs_taken = 0;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;
   int unsigned settings_used = 0;
   int unsigned status_seen [8];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // Computes the answer to one beat and updates the table as the block should.
   function automatic reply_type nearest_point_reply(job_type j);
      reply_type r;
      int unsigned span;
      bit found;
      int unsigned best;
      logic [DW-1:0] best_d;
      logic [DW-1:0] d;
      logic signed [CW:0] dx;
      logic signed [CW:0] dy;
      r = '0;
      found = 1'b0;
      best = 0;
      best_d = '0;
      if (j.mode == MODE_LOAD) begin
         pt_x[j.slot] = j.x;
         pt_y[j.slot] = j.y;
         pt_ident[j.slot] = j.ident;
         pt_idle[j.slot] = j.idle;
         r.status = STAT_LOADED;
      end else if (!j.pending) begin
         r.status = STAT_NOT_PENDING;
      end else if (j.rider == 0 || j.rider > cfg_riders) begin
         r.status = STAT_BAD_RIDER;
      end else begin
         span = (cfg_drivers > SLOTS) ? SLOTS : cfg_drivers;
         for (int unsigned i = 0; i < span; i++) begin
            if (pt_idle[i]) begin
               dx = pt_x[i] - j.x;
               dy = pt_y[i] - j.y;
               d = dx*dx + dy*dy;
               // Strict compare: the lowest slot keeps a tie.
               if (!found || d < best_d) begin
                  found = 1'b1;
                  best_d = d;
                  best = i;
               end
            end
         end
         if (!found) begin
            r.status = STAT_NO_IDLE;
         end else begin
            pt_idle[best] = 1'b0;
            if (tally != TOTAL_MAX) tally++;
            r.status = STAT_MATCHED;
            r.slot = SLOT_PORT_W'(best);
            r.ident = pt_ident[best];
            r.sq_dist = best_d;
         end
      end
      r.total = tally;
      return r;
   endfunction

   // Driver: one beat at a time from the queue, each after its own gap.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         carrying = 1'b0;
      end else begin
         if (start && !busy) begin
            pending_replies.push_back(nearest_point_reply(cur_job));
            jobs_taken++;
            carrying = 1'b0;
         end
         if (!carrying && pending_jobs.size() != 0) begin
            if (pending_jobs[0].gap != 0) begin
               pending_jobs[0].gap--;
            end else begin
               cur_job = pending_jobs.pop_front();
               carrying = 1'b1;
               req_mode <= cur_job.mode;
               req_slot_index <= cur_job.slot;
               req_pos_x <= cur_job.x;
               req_pos_y <= cur_job.y;
               req_server_id <= cur_job.ident;
               req_server_idle <= cur_job.idle;
               req_rider_id <= cur_job.rider;
               req_ride_pending <= cur_job.pending;
            end
         end
         start <= carrying;
      end
   end

   task automatic check_field(input string name, input logic [DW-1:0] want,
                              input logic [DW-1:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= ERROR_PRINT_CAP)
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      end
   endtask

   // Monitor and watchdog.
   always @(posedge clock) begin
      reply_type want;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_strobe) begin
            if (pending_replies.size() == 0) begin
               mismatches++;
               if (mismatches <= ERROR_PRINT_CAP)
                  $error("result beat with nothing outstanding, status %0d", rsp_status);
            end else begin
               want = pending_replies.pop_front();
               status_seen[want.status]++;
               check_field("status", want.status, rsp_status);
               check_field("chosen_slot", want.slot, rsp_chosen_slot);
               check_field("chosen_id", want.ident, rsp_chosen_id);
               check_field("distance_squared", want.sq_dist, rsp_distance_squared);
               check_field("match_total", want.total, rsp_match_total);
            end
         end
         if (rsp_strobe || (start && !busy)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
               $error("no beat moved for %0d cycles", quiet_cycles);
               $display("TB_ERROR");
               $finish;
            end
         end
      end
   end

   task automatic wait_until_drained();
      do @(negedge clock);
      while (pending_jobs.size() != 0 || carrying || pending_replies.size() != 0 || busy);
   endtask

   task automatic program_regs(input bit [DRV_COUNT_W-1:0] drivers,
                               input bit [RIDER_W-1:0] riders);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_DRIVER_COUNT;
      csr_wdata <= CSR_DATA_W'(drivers);
      @(posedge clock);
      csr_index <= CSR_RIDER_COUNT;
      csr_wdata <= riders;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_drivers = drivers;
      cfg_riders = riders;
      settings_used++;
      @(negedge clock);
   endtask

   function automatic job_type load_job(bit [SLOT_PORT_W-1:0] slot, bit signed [CW-1:0] x,
                                        bit signed [CW-1:0] y, bit [SERVER_ID_W-1:0] ident,
                                        bit idle);
      job_type j;
      j.mode = MODE_LOAD;
      j.slot = slot;
      j.x = x;
      j.y = y;
      j.ident = ident;
      j.idle = idle;
      j.rider = RIDER_W'($urandom);
      j.pending = 1'($urandom);
      j.gap = 0;
      return j;
   endfunction

   function automatic job_type request_job(bit signed [CW-1:0] x, bit signed [CW-1:0] y,
                                           bit [RIDER_W-1:0] rider, bit pending);
      job_type j;
      j.mode = MODE_REQUEST;
      j.slot = SLOT_PORT_W'($urandom);
      j.x = x;
      j.y = y;
      j.ident = SERVER_ID_W'($urandom);
      j.idle = 1'($urandom);
      j.rider = rider;
      j.pending = pending;
      j.gap = 0;
      return j;
   endfunction

   // Mixes full-range values, the two extremes and tight clusters that force ties.
   function automatic bit signed [CW-1:0] pick_coord();
      int v;
      case ($urandom_range(0, 4))
         0: return CW'($urandom);
         1: begin
            v = $urandom_range(0, 8);
            return CW'(v - 4);
         end
         2: begin
            v = $urandom_range(0, 2000);
            return CW'(v - 1000);
         end
         3: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
         default: begin
            v = $urandom_range(0, 200000);
            return CW'(v - 100000);
         end
      endcase
   endfunction

   function automatic int unsigned draw_gap(int unsigned style);
      case (style)
         0: return 0;
         1: return $urandom_range(0, 18);
         default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
      endcase
   endfunction

   function automatic job_type random_job(int unsigned style);
      job_type j;
      int unsigned span;
      bit [SLOT_PORT_W-1:0] slot;
      bit [RIDER_W-1:0] rider;
      span = (cfg_drivers > SLOTS) ? SLOTS : cfg_drivers;
      if ($urandom_range(0, 99) < 45) begin
         // Loads mostly land inside the scanned range to keep points idle.
         if (span != 0 && $urandom_range(0, 4) != 0)
            slot = SLOT_PORT_W'($urandom_range(0, span - 1));
         else
            slot = SLOT_PORT_W'($urandom_range(0, SLOTS - 1));
         j = load_job(slot, pick_coord(), pick_coord(), SERVER_ID_W'($urandom),
                      $urandom_range(0, 3) != 0);
      end else begin
         case ($urandom_range(0, 9))
            0: rider = '0;
            1: rider = cfg_riders + 1'b1;
            2: rider = RIDER_W'($urandom);
            default: rider = (cfg_riders != 0) ? RIDER_W'($urandom_range(1, cfg_riders))
                                               : RIDER_W'($urandom);
         endcase
         j = request_job(pick_coord(), pick_coord(), rider, $urandom_range(0, 9) != 0);
      end
      j.gap = draw_gap(style);
      return j;
   endfunction

   // Two bursts with a full drain between them, each with its own idling style.
   task automatic random_phase(input bit [DRV_COUNT_W-1:0] drivers,
                               input bit [RIDER_W-1:0] riders, input int unsigned count);
      int unsigned style;
      program_regs(drivers, riders);
      for (int half = 0; half < 2; half++) begin
         style = $urandom_range(0, 2);
         for (int unsigned n = 0; n < count / 2; n++)
            pending_jobs.push_back(random_job(style));
         wait_until_drained();
      end
   endtask

   bit [DRV_COUNT_W-1:0] phase_drivers [11] = '{1, 2, 8, 16, 0, 256, 511, 5, 257, 3, 40};
   bit [RIDER_W-1:0]     phase_riders  [11] = '{65535, 3, 1000, 65535, 50, 65535,
                                                65535, 0, 200, 7, 40000};
   int unsigned          phase_items   [11] = '{140, 140, 200, 200, 50, 50, 40, 50, 30,
                                                220, 160};

   initial begin
      job_type j;
      int unsigned fill_style;
      int unsigned rounds;
      do @(negedge clock);
      while (reset);

      // Every slot gets written before any scan can touch it.
      program_regs(9'd4, 16'd10);
      fill_style = 2;
      for (int s = 0; s < SLOTS; s++) begin
         j = load_job(SLOT_PORT_W'(s), pick_coord(), pick_coord(), SERVER_ID_W'($urandom),
                      1'($urandom));
         j.gap = draw_gap(fill_style);
         pending_jobs.push_back(j);
      end
      wait_until_drained();

      // Directed sequence: four slots scanned, riders 1 to 10 valid.
      pending_jobs.push_back(load_job(0, COORD_MIN, COORD_MIN, 16'hFFFF, 1'b1));
      pending_jobs.push_back(load_job(1, COORD_MAX, COORD_MAX, 16'h0000, 1'b0));
      pending_jobs.push_back(load_job(2, 0, 0, 16'h1234, 1'b0));
      pending_jobs.push_back(load_job(3, 0, 0, 16'h4321, 1'b0));
      // An idle point just past the scanned range must be ignored.
      pending_jobs.push_back(load_job(4, COORD_MAX, COORD_MAX, 16'hBEEF, 1'b1));
      // Not pending wins over a bad rider id.
      pending_jobs.push_back(request_job(COORD_MAX, COORD_MAX, 16'd0, 1'b0));
      pending_jobs.push_back(request_job(COORD_MAX, COORD_MAX, 16'd0, 1'b1));
      pending_jobs.push_back(request_job(COORD_MAX, COORD_MAX, 16'd11, 1'b1));
      // Largest possible distance, then nothing idle is left.
      pending_jobs.push_back(request_job(COORD_MAX, COORD_MAX, 16'd10, 1'b1));
      pending_jobs.push_back(request_job(0, 0, 16'd1, 1'b1));
      // Equal distances: the lower slot goes first.
      pending_jobs.push_back(load_job(1, 10, 0, 16'h0AAA, 1'b1));
      pending_jobs.push_back(load_job(2, -10, 0, 16'h0555, 1'b1));
      pending_jobs.push_back(request_job(0, 0, 16'd5, 1'b1));
      pending_jobs.push_back(request_job(0, 0, 16'd5, 1'b1));
      pending_jobs.push_back(load_job(3, 3, 4, 16'h3333, 1'b1));
      pending_jobs.push_back(load_job(0, -3, -4, 16'h7777, 1'b1));
      pending_jobs.push_back(request_job(0, 0, 16'd10, 1'b1));
      pending_jobs.push_back(request_job(COORD_MIN, COORD_MIN, 16'd1, 1'b1));
      pending_jobs.push_back(request_job(0, 0, 16'd1, 1'b0));
      pending_jobs.push_back(request_job(0, 0, 16'd1, 1'b1));
      wait_until_drained();

      for (int p = 0; p < 11; p++)
         random_phase(phase_drivers[p], phase_riders[p], phase_items[p]);

      // Back-to-back load and match pairs on one slot.
      program_regs(9'd1, 16'hFFFF);
      rounds = PAIR_ROUNDS;
      for (int unsigned n = 0; n < rounds; n++) begin
         pending_jobs.push_back(load_job(0, pick_coord(), pick_coord(),
                                         SERVER_ID_W'($urandom), 1'b1));
         pending_jobs.push_back(request_job(pick_coord(), pick_coord(), 16'd1, 1'b1));
      end
      wait_until_drained();

      random_phase(9'd6, 16'hFFFF, 150);

      wait_until_drained();
      repeat (300) @(posedge clock);
      $display("Covered %0d beats: %0d loads, %0d matched, %0d without an idle point,",
               jobs_taken, status_seen[STAT_LOADED], status_seen[STAT_MATCHED],
               status_seen[STAT_NO_IDLE]);
      $display("%0d not pending, %0d bad riders, %0d register settings, tally ended at %0d.",
               status_seen[STAT_NOT_PENDING], status_seen[STAT_BAD_RIDER], settings_used,
               tally);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
